FILE: hw/rtl/lrcp_pkg.sv
`default_nettype none
package lrcp_pkg;

  localparam int OFF_W  = 32;
  localparam int ACC_W  = OFF_W + 4;
  localparam int MS_W   = 23;
  localparam int SUM_W  = (OFF_W > 32) ? OFF_W + 2 : 34;
  localparam int TIME_W = 32;

  localparam logic [4:0] PH_WS        = 5'd0;
  localparam logic [4:0] PH_OPEN      = 5'd1;
  localparam logic [4:0] PH_OFFTAG    = 5'd2;
  localparam logic [4:0] PH_M2        = 5'd3;
  localparam logic [4:0] PH_COLON     = 5'd4;
  localparam logic [4:0] PH_S1        = 5'd5;
  localparam logic [4:0] PH_S2        = 5'd6;
  localparam logic [4:0] PH_AFTER_SEC = 5'd7;
  localparam logic [4:0] PH_FRAC      = 5'd8;
  localparam logic [4:0] PH_AFTER_TAG = 5'd9;
  localparam logic [4:0] PH_OFF_WS    = 5'd10;
  localparam logic [4:0] PH_OFF_NUM   = 5'd11;
  localparam logic [4:0] PH_OFF_REST  = 5'd12;
  localparam logic [4:0] PH_IDLE      = 5'd13;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_LBR   = 8'd91;
  localparam logic [7:0] CH_RBR   = 8'd93;
  localparam logic [7:0] CH_LOW_O = 8'd111;

  typedef struct packed {
    logic                    emit;
    logic                    first;
    logic [6:0]              minutes;
    logic [6:0]              seconds;
    logic [9:0]              fraction;
    logic [1:0]              frac_digits;
    logic signed [OFF_W-1:0] offset;
  } lrcp_stamp_t;

  // "[offset:" one character per index
  function automatic logic [7:0] offset_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0: ch = 8'd91;
      3'd1: ch = 8'd111;
      3'd2: ch = 8'd102;
      3'd3: ch = 8'd102;
      3'd4: ch = 8'd115;
      3'd5: ch = 8'd101;
      3'd6: ch = 8'd116;
      default: ch = 8'd58;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/lrc_timestamp_stream_parser.sv
// Flow: a byte accepted into the input register steps the parser when it advances and,
// if it closes a tag, its word is loaded into the result register behind the out_ ports.
// Throughput: one byte per cycle, set by the single-pass parser step; stalls on
// out_stall only once both the input and result registers are full.
// Reset: synchronous rst_n clears both valid bits, the line state and the offset.
`default_nettype none
module lrc_timestamp_stream_parser
  import lrcp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_byte_in,
  input  wire logic              in_body_start,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [TIME_W-1:0]      out_time_ms,
  output logic                   out_first_in_line
);

  logic              s1_valid_r;
  logic [7:0]        s1_byte_r;
  logic              s1_start_r;
  logic              advance;
  logic              out_valid_r;
  logic [TIME_W-1:0] time_r;
  logic              first_r;
  lrcp_stamp_t       stamp;
  logic [TIME_W-1:0] time_ms;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;

  lrcp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .byte_in    (s1_byte_r),
    .body_start (s1_start_r),
    .stamp      (stamp)
  );

  lrcp_stamp u_stamp (
    .stamp   (stamp),
    .time_ms (time_ms)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r  <= in_byte_in;
      s1_start_r <= in_body_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= stamp.emit;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stamp.emit) begin
      time_r  <= time_ms;
      first_r <= stamp.first;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_time_ms       = time_r;
  assign out_first_in_line = first_r;

endmodule
`default_nettype wire

FILE: hw/rtl/lrcp_parser.sv
`default_nettype none
module lrcp_parser
  import lrcp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  byte_in,
  input  wire logic        body_start,
  output lrcp_stamp_t      stamp
);

  logic [4:0]              phase_r, phase_nxt, cur_phase;
  logic [6:0]              min_r, min_nxt, cur_min;
  logic [6:0]              sec_r, sec_nxt, cur_sec;
  logic [9:0]              frac_r, frac_nxt, cur_frac;
  logic [1:0]              fcnt_r, fcnt_nxt, cur_fcnt;
  logic signed [OFF_W-1:0] off_r, off_nxt, cur_off;
  logic [OFF_W-1:0]        acc_r, acc_nxt, cur_acc;
  logic                    neg_r, neg_nxt, cur_neg;
  logic [3:0]              pos_r, pos_nxt, cur_pos;
  logic                    has_r, has_nxt, cur_has;

  logic                    is_dig;
  logic [3:0]              dig;
  logic                    off_ws;
  logic [OFF_W-1:0]        lim;
  logic [ACC_W-1:0]        acc_x;
  logic [OFF_W-1:0]        acc_step;
  logic signed [OFF_W-1:0] commit_val;
  logic [3:0]              pos_inc;

  assign is_dig  = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
  assign dig     = 4'(byte_in - CH_ZERO);
  assign off_ws  = (byte_in == CH_SP) || ((byte_in >= CH_TAB) && (byte_in <= CH_CR));
  assign lim     = {1'b1, {(OFF_W-1){1'b0}}};
  assign pos_inc = cur_pos + 4'd1;

  // saturate when acc*10 + d would pass the limit
  assign acc_x    = ({4'b0, cur_acc} << 3) + ({4'b0, cur_acc} << 1) + ACC_W'(dig);
  assign acc_step = (acc_x > {4'b0, lim}) ? lim : acc_x[OFF_W-1:0];

  always_comb begin
    if (cur_neg) begin
      commit_val = signed'(-cur_acc);
    end else if (cur_acc >= lim) begin
      commit_val = signed'(lim - 1'b1);
    end else begin
      commit_val = signed'(cur_acc);
    end
  end

  always_comb begin
    if (body_start) begin
      cur_phase = PH_WS;
      cur_min   = '0;
      cur_sec   = '0;
      cur_frac  = '0;
      cur_fcnt  = '0;
      cur_off   = '0;
      cur_acc   = '0;
      cur_neg   = 1'b0;
      cur_pos   = '0;
      cur_has   = 1'b0;
    end else begin
      cur_phase = phase_r;
      cur_min   = min_r;
      cur_sec   = sec_r;
      cur_frac  = frac_r;
      cur_fcnt  = fcnt_r;
      cur_off   = off_r;
      cur_acc   = acc_r;
      cur_neg   = neg_r;
      cur_pos   = pos_r;
      cur_has   = has_r;
    end
  end

  always_comb begin
    phase_nxt = cur_phase;
    min_nxt   = cur_min;
    sec_nxt   = cur_sec;
    frac_nxt  = cur_frac;
    fcnt_nxt  = cur_fcnt;
    off_nxt   = cur_off;
    acc_nxt   = cur_acc;
    neg_nxt   = cur_neg;
    pos_nxt   = cur_pos;
    has_nxt   = cur_has;
    stamp.emit        = 1'b0;
    stamp.first       = !cur_has;
    stamp.minutes     = cur_min;
    stamp.seconds     = cur_sec;
    stamp.fraction    = cur_frac;
    stamp.frac_digits = cur_fcnt;
    stamp.offset      = cur_off;

    if (byte_in == CH_LF) begin
      phase_nxt = PH_WS;
      min_nxt   = '0;
      sec_nxt   = '0;
      frac_nxt  = '0;
      fcnt_nxt  = '0;
      acc_nxt   = '0;
      neg_nxt   = 1'b0;
      pos_nxt   = '0;
      has_nxt   = 1'b0;
    end else begin
      unique case (cur_phase)
        PH_WS: begin
          if (!(byte_in == CH_SP || byte_in == CH_TAB || byte_in == CH_CR)) begin
            phase_nxt = (byte_in == CH_LBR) ? PH_OPEN : PH_IDLE;
          end
        end
        PH_OPEN: begin
          if (is_dig) begin
            min_nxt   = 7'(dig);
            phase_nxt = PH_M2;
          end else if (!cur_has && byte_in == CH_LOW_O) begin
            pos_nxt   = 4'd2;
            phase_nxt = PH_OFFTAG;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_OFFTAG: begin
          if (!cur_pos[3] && byte_in == offset_char(cur_pos[2:0])) begin
            pos_nxt = pos_inc;
            if (pos_inc[3]) begin
              acc_nxt   = '0;
              neg_nxt   = 1'b0;
              phase_nxt = PH_OFF_WS;
            end
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_M2: begin
          if (is_dig) begin
            min_nxt   = 7'((cur_min << 3) + (cur_min << 1) + 7'(dig));
            phase_nxt = PH_COLON;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_COLON: begin
          phase_nxt = (byte_in == CH_COLON) ? PH_S1 : PH_IDLE;
        end
        PH_S1: begin
          if (is_dig) begin
            sec_nxt   = 7'(dig);
            phase_nxt = PH_S2;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_S2: begin
          if (is_dig) begin
            sec_nxt   = 7'((cur_sec << 3) + (cur_sec << 1) + 7'(dig));
            phase_nxt = PH_AFTER_SEC;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_AFTER_SEC, PH_FRAC: begin
          priority if (cur_phase == PH_AFTER_SEC &&
                       (byte_in == CH_DOT || byte_in == CH_COLON)) begin
            frac_nxt  = '0;
            fcnt_nxt  = '0;
            phase_nxt = PH_FRAC;
          end else if (cur_phase == PH_FRAC && is_dig && cur_fcnt != 2'd3) begin
            frac_nxt = 10'((cur_frac << 3) + (cur_frac << 1) + 10'(dig));
            fcnt_nxt = cur_fcnt + 2'd1;
          end else if (byte_in == CH_RBR) begin
            if (cur_phase == PH_AFTER_SEC) begin
              fcnt_nxt          = '0;
              stamp.frac_digits = '0;
            end
            stamp.emit = 1'b1;
            has_nxt    = 1'b1;
            phase_nxt  = PH_AFTER_TAG;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_AFTER_TAG: begin
          phase_nxt = (byte_in == CH_LBR) ? PH_OPEN : PH_IDLE;
        end
        PH_OFF_WS, PH_OFF_NUM, PH_OFF_REST: begin
          priority if (byte_in == CH_RBR) begin
            off_nxt   = commit_val;
            phase_nxt = PH_IDLE;
          end else if (cur_phase == PH_OFF_WS && off_ws) begin
            phase_nxt = PH_OFF_WS;
          end else if (cur_phase == PH_OFF_WS &&
                       (byte_in == CH_PLUS || byte_in == CH_MINUS)) begin
            neg_nxt   = (byte_in == CH_MINUS);
            phase_nxt = PH_OFF_NUM;
          end else if (cur_phase != PH_OFF_REST && is_dig) begin
            acc_nxt   = acc_step;
            phase_nxt = PH_OFF_NUM;
          end else begin
            phase_nxt = PH_OFF_REST;
          end
        end
        default: begin
          phase_nxt = cur_phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WS;
      min_r   <= '0;
      sec_r   <= '0;
      frac_r  <= '0;
      fcnt_r  <= '0;
      off_r   <= '0;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      pos_r   <= '0;
      has_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      min_r   <= min_nxt;
      sec_r   <= sec_nxt;
      frac_r  <= frac_nxt;
      fcnt_r  <= fcnt_nxt;
      off_r   <= off_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      pos_r   <= pos_nxt;
      has_r   <= has_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lrcp_stamp.sv
`default_nettype none
module lrcp_stamp
  import lrcp_pkg::*;
(
  input  wire lrcp_stamp_t       stamp,
  output logic [TIME_W-1:0]      time_ms
);

  logic [9:0]              frac_ms;
  logic [MS_W-1:0]         ms;
  logic signed [SUM_W-1:0] sum;

  always_comb begin
    unique case (stamp.frac_digits)
      2'd0: frac_ms = '0;
      2'd1: frac_ms = 10'(stamp.fraction * 10'd100);
      2'd2: frac_ms = 10'(stamp.fraction * 10'd10);
      default: frac_ms = stamp.fraction;
    endcase
  end

  assign ms  = MS_W'(MS_W'(stamp.minutes) * MS_W'(60000))
             + MS_W'(MS_W'(stamp.seconds) * MS_W'(1000))
             + MS_W'(frac_ms);
  assign sum = signed'(SUM_W'(ms)) + SUM_W'(stamp.offset);

  always_comb begin
    if (sum[SUM_W-1]) begin
      time_ms = '0;
    end else if (|sum[SUM_W-2:TIME_W]) begin
      time_ms = '1;
    end else begin
      time_ms = sum[TIME_W-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lrcp_checker.sv
`default_nettype none
module lrcp_checker
  import lrcp_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic [7:0]        in_byte_in,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [TIME_W-1:0] out_time_ms,
  input wire logic              out_first_in_line
);

  // held word under stall
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_time_ms) &&
                               $stable(out_first_in_line))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // input only backs up when the result register is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // a newline never yields a word
  a_newline_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_byte_in == CH_LF ##1 !out_valid |=> !out_valid)
    else $error("word produced by newline");

endmodule

bind lrc_timestamp_stream_parser lrcp_checker u_lrcp_checker (.*);
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import lrcp_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  class stamp_scoreboard;
    typedef struct {
      logic [31:0] time_ms;
      logic        first;
    } stamp_t;

    stamp_t due_stamps[$];
    int errors;
    string offset_word;

    logic [4:0] phase;
    int unsigned mins, secs, frac, frac_cnt, tag_pos;
    longint unsigned offset_now;
    longint unsigned offset_mag;
    bit off_neg, line_stamped;

    function new();
      errors = 0;
      offset_word = "[offset:";
      drop_line();
      offset_now = 0;
    endfunction

    function void drop_line();
      phase = PH_WS;
      mins = 0;
      secs = 0;
      frac = 0;
      frac_cnt = 0;
      offset_mag = 0;
      off_neg = 0;
      tag_pos = 0;
      line_stamped = 0;
    endfunction

    function logic [31:0] stamp_ms();
      longint unsigned f, ms, mag;
      case (frac_cnt)
        0: f = 0;
        1: f = 64'(frac) * 100;
        2: f = 64'(frac) * 10;
        default: f = 64'(frac);
      endcase
      ms = 64'(mins) * 60000 + 64'(secs) * 1000 + f;
      if (offset_now[63]) begin
        mag = 64'd0 - offset_now;
        if (mag >= ms) return 32'd0;
        ms = ms - mag;
        return ms[31:0];
      end
      ms = ms + offset_now;
      if (ms > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
      return ms[31:0];
    endfunction

    function int pending();
      return due_stamps.size();
    endfunction

    function void note_byte(input logic [7:0] c, input logic bs);
      int unsigned d;
      bit dig, skip;
      longint unsigned lim;
      stamp_t s;
      d = 32'(c) - 32'(CH_ZERO);
      dig = (c >= CH_ZERO) && (c <= CH_NINE);
      lim = 64'd1 << (OFF_W - 1);
      skip = 0;
      if (bs) begin
        drop_line();
        offset_now = 0;
      end
      if (c == CH_LF) begin
        drop_line();
        return;
      end
      case (phase)
        PH_WS: begin
          if (!(c == CH_SP || c == CH_TAB || c == CH_CR))
            phase = (c == CH_LBR) ? PH_OPEN : PH_IDLE;
        end
        PH_OPEN: begin
          if (dig) begin
            mins = d;
            phase = PH_M2;
          end else if (!line_stamped && c == CH_LOW_O) begin
            tag_pos = 2;
            phase = PH_OFFTAG;
          end else phase = PH_IDLE;
        end
        PH_OFFTAG: begin
          if (tag_pos < 8 && c == offset_word[tag_pos]) begin
            tag_pos++;
            if (tag_pos >= 8) begin
              offset_mag = 0;
              off_neg = 0;
              phase = PH_OFF_WS;
            end
          end else phase = PH_IDLE;
        end
        PH_M2: begin
          if (dig) begin
            mins = mins * 10 + d;
            phase = PH_COLON;
          end else phase = PH_IDLE;
        end
        PH_COLON: phase = (c == CH_COLON) ? PH_S1 : PH_IDLE;
        PH_S1: begin
          if (dig) begin
            secs = d;
            phase = PH_S2;
          end else phase = PH_IDLE;
        end
        PH_S2: begin
          if (dig) begin
            secs = secs * 10 + d;
            phase = PH_AFTER_SEC;
          end else phase = PH_IDLE;
        end
        PH_AFTER_SEC, PH_FRAC: begin
          if (phase == PH_AFTER_SEC && (c == CH_DOT || c == CH_COLON)) begin
            frac = 0;
            frac_cnt = 0;
            phase = PH_FRAC;
          end else if (phase == PH_FRAC && dig && frac_cnt < 3) begin
            frac = frac * 10 + d;
            frac_cnt++;
          end else if (c == CH_RBR) begin
            if (phase == PH_AFTER_SEC) frac_cnt = 0;
            s.time_ms = stamp_ms();
            s.first = !line_stamped;
            line_stamped = 1;
            phase = PH_AFTER_TAG;
            due_stamps = {due_stamps, s};
          end else phase = PH_IDLE;
        end
        PH_AFTER_TAG: phase = (c == CH_LBR) ? PH_OPEN : PH_IDLE;
        PH_OFF_WS, PH_OFF_NUM, PH_OFF_REST: begin
          if (c == CH_RBR) begin
            if (off_neg) offset_now = 64'd0 - offset_mag;
            else offset_now = (offset_mag >= lim) ? lim - 1 : offset_mag;
            phase = PH_IDLE;
          end else begin
            if (phase == PH_OFF_WS) begin
              if (c == CH_SP || (c >= CH_TAB && c <= CH_CR)) skip = 1;
              else if (c == CH_PLUS || c == CH_MINUS) begin
                off_neg = (c == CH_MINUS);
                phase = PH_OFF_NUM;
                skip = 1;
              end else phase = PH_OFF_NUM;
            end
            if (!skip && phase == PH_OFF_NUM) begin
              if (dig) begin
                if (offset_mag > (lim - d) / 10) offset_mag = lim;
                else offset_mag = offset_mag * 10 + d;
              end else phase = PH_OFF_REST;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check(input logic [31:0] t, input logic f);
      stamp_t s;
      if (due_stamps.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, time_ms=%0d first_in_line=%0b", $time, t, f);
        return;
      end
      s = due_stamps.pop_front();
      if (t !== s.time_ms) begin
        errors++;
        $display("%0t: time_ms expected %0d, got %0d", $time, s.time_ms, t);
      end
      if (f !== s.first) begin
        errors++;
        $display("%0t: first_in_line expected %0b, got %0b", $time, s.first, f);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [7:0] in_byte_in;
  logic in_body_start;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TIME_W-1:0] out_time_ms;
  logic out_first_in_line;

  stamp_scoreboard sb;
  int idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;
  logic [7:0] line_buf[$];

  lrc_timestamp_stream_parser dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte_in(in_byte_in),
    .in_body_start(in_body_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_time_ms(out_time_ms),
    .out_first_in_line(out_first_in_line)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_valid && !in_stall) sb.note_byte(in_byte_in, in_body_start);
      if (out_valid && !out_stall) sb.check(out_time_ms, out_first_in_line);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void put(input logic [7:0] b);
    line_buf = {line_buf, b};
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void put_two(input int v);
    put(8'(CH_ZERO + v / 10));
    put(8'(CH_ZERO + v % 10));
  endfunction

  function automatic logic [7:0] pick_ws();
    case ($urandom_range(0, 2))
      0: return CH_SP;
      1: return CH_TAB;
      default: return CH_CR;
    endcase
  endfunction

  function automatic int pick_field();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 99;
      default: return $urandom_range(0, 99);
    endcase
  endfunction

  function automatic void put_stamp();
    int k;
    put(CH_LBR);
    put_two(pick_field());
    put(CH_COLON);
    put_two(pick_field());
    k = $urandom_range(0, 3);
    if (k != 0) begin
      put((k == 2) ? CH_COLON : CH_DOT);
      repeat ($urandom_range((k == 3) ? 1 : 0, (k == 3) ? 4 : 3))
        put(8'(CH_ZERO + $urandom_range(0, 9)));
    end
    put(CH_RBR);
  endfunction

  function automatic void put_offset();
    int n;
    put_str("[offset:");
    if ($urandom_range(0, 4) == 0) put(pick_ws());
    case ($urandom_range(0, 2))
      0: put(CH_PLUS);
      1: put(CH_MINUS);
      default: ;
    endcase
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 7);
    repeat (n) put(8'(CH_ZERO + $urandom_range(0, 9)));
    if ($urandom_range(0, 5) == 0) put(8'($urandom_range(32, 126)));
    if ($urandom_range(0, 9) != 0) put(CH_RBR);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic bs);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      in_byte_in = 8'($urandom_range(0, 255));
      in_body_start = 1'($urandom_range(0, 1));
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_byte_in = b;
    in_body_start = bs;
    bytes_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_line(input int start_at);
    for (int i = 0; i < line_buf.size(); i++) send_byte(line_buf[i], i == start_at);
    line_buf.delete();
  endtask

  task automatic send_text(input string s, input int start_at);
    line_buf.delete();
    put_str(s);
    send_line(start_at);
  endtask

  task automatic emit_line();
    int kind, n, start_at;
    kind = $urandom_range(0, 99);
    line_buf.delete();
    repeat ($urandom_range(0, 2)) put(pick_ws());
    if (kind < 60) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        if (i > 0 && $urandom_range(0, 19) == 0) put(CH_SP);
        if (i == 1 && $urandom_range(0, 9) == 0) put_offset();
        else put_stamp();
      end
    end else if (kind < 82) begin
      put_offset();
      if ($urandom_range(0, 3) == 0) put_stamp();
    end else if (kind < 90) begin
      n = $urandom_range(1, 7);
      for (int i = 0; i < n; i++) put(sb.offset_word[i]);
      put(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 12)) put(8'($urandom_range(0, 255)));
    end
    repeat ($urandom_range(0, 5)) put(8'($urandom_range(32, 126)));
    if ($urandom_range(0, 7) == 0)
      line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
    put(CH_LF);
    case ($urandom_range(0, 29))
      0, 1: start_at = 0;
      2: start_at = $urandom_range(0, line_buf.size() - 1);
      default: start_at = -1;
    endcase
    send_line(start_at);
  endtask

  task automatic run_phase(input int idle, input int stall, input int n_bytes);
    int first_byte;
    idle_pct = idle;
    stall_pct = stall;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < n_bytes) emit_line();
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte_in = 8'd0;
    in_body_start = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_text("[99:99.999][00:00:5][01:00.]\n", 0);
    line_buf.delete();
    put(CH_SP);
    put(CH_TAB);
    put(CH_CR);
    put_str("[offset:-99999999999]\n[12:34][offset:5]\n");
    send_line(-1);
    send_text("[offset:+99999999999]\n[99:99.999]\n[offset:7\n[00:01] [00:02]\n", -1);
    send_text("[00:01.1234]\n[offset:]\n[00:00]\n", -1);

    run_phase(0, 0, 110);
    run_phase(69, 0, 110);
    run_phase(0, 69, 110);
    run_phase(8, 8, 110);

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("testbench: errors");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/lrcp_pkg.sv
hw/rtl/lrcp_parser.sv
hw/rtl/lrcp_stamp.sv
hw/rtl/lrc_timestamp_stream_parser.sv
hw/rtl/lrcp_checker.sv
dv/testbench.sv
